// ===== rtl/firq15_pkg.sv =====
// ----------------------------------------------------------------------------
// firq15_pkg
// Shared constants, types and the coefficient table of the Q15 FIR filter.
// ----------------------------------------------------------------------------
package firq15_pkg;

   localparam int TAPS       = 31;
   localparam int HIST_LEN   = TAPS - 1;
   localparam int COEF_COUNT = 31;
   localparam int IDX_W      = $clog2(TAPS);
   localparam int HIST_W     = (HIST_LEN > 1) ? $clog2(HIST_LEN) : 1;
   localparam int SAMPLE_W   = 16;
   localparam int COEF_W     = 16;
   localparam int ACC_W      = 32;

   typedef logic signed [COEF_W-1:0]   coef_type;
   typedef logic signed [SAMPLE_W-1:0] sample_type;
   typedef logic signed [ACC_W-1:0]    acc_type;

   typedef struct packed {
      logic clear;
      logic mul_en;
      logic acc_en;
   } mac_ctrl_type;

   localparam coef_type COEF_TABLE [COEF_COUNT] = '{
      16'sd6,     16'sd52,    -16'sd41,   16'sd62,    16'sd56,    -16'sd231,
      16'sd169,   -16'sd377,  -16'sd727,  16'sd86,    -16'sd1904, -16'sd1084,
      -16'sd290,  -16'sd5298, 16'sd3127,  16'sd24765, 16'sd3127,  -16'sd5298,
      -16'sd290,  -16'sd1084, -16'sd1904, 16'sd86,    -16'sd727,  -16'sd377,
      16'sd169,   -16'sd231,  16'sd56,    16'sd62,    -16'sd41,   16'sd52,
      16'sd6
   };

   // taps beyond the table weigh zero
   function automatic coef_type coef_at(input logic [IDX_W-1:0] j);
      coef_type c;
      c = '0;
      if (int'(j) < COEF_COUNT) begin
         c = COEF_TABLE[j];
      end
      return c;
   endfunction

endpackage

// ===== rtl/firq15_mac.sv =====
// ----------------------------------------------------------------------------
// firq15_mac
// Shared multiply-accumulate unit: registered 16x16 product, 32-bit sum.
// ----------------------------------------------------------------------------
module firq15_mac (
   input  logic                   clock,
   input  firq15_pkg::mac_ctrl_type ctrl,
   input  firq15_pkg::coef_type   coef,
   input  firq15_pkg::sample_type data,
   output firq15_pkg::acc_type    acc
);

   firq15_pkg::acc_type prod_ff;
   firq15_pkg::acc_type acc_ff;

   always_ff @(posedge clock) begin
      if (ctrl.mul_en) begin
         prod_ff <= firq15_pkg::acc_type'(coef * data);
      end
      if (ctrl.clear) begin
         acc_ff <= '0;
      end else if (ctrl.acc_en) begin
         acc_ff <= acc_ff + prod_ff;
      end
   end

   assign acc = acc_ff;

endmodule

// ===== rtl/fir_filter_q15_saturating.sv =====
// ----------------------------------------------------------------------------
// fir_filter_q15_saturating
// 31-tap Q15 FIR filter, one 16-bit sample word in, one filtered word out.
// ----------------------------------------------------------------------------
// Input channel req_: req_sample is taken when req_valid is high and
// req_stall is low. req_stall is high while a sample is being filtered.
// Result channel rsp_: rsp_filtered_sample is held in an output register and
// is taken when rsp_valid is high and rsp_stall is low.
// Each sample runs one multiply per tap through the single shared
// multiply-accumulate unit (RUN), then DRAIN empties the product register
// and DONE loads the output register. The input is free again once the
// result is loaded, so a new sample is taken only after the last one's
// result has gone into the output register.
// If the receiver stalls, a finished result waits inside the block until the
// output register frees; a new sample may be taken while an earlier result
// still sits in the output register.
// Synchronous reset clears the 30-entry delay line to zero, drops any word
// in flight and empties the output register.
// The 32-bit sum is shifted right arithmetically by 16; for these taps the
// result always fits in 16 bits.
// ----------------------------------------------------------------------------
module fir_filter_q15_saturating (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic signed [15:0] req_sample,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic signed [15:0] rsp_filtered_sample
);

   typedef enum logic [1:0] {IDLE, RUN, DRAIN, DONE} state_type;

   state_type state_ff, state_in;
   logic [firq15_pkg::IDX_W-1:0] idx_ff, idx_in;
   firq15_pkg::sample_type x_ff, x_in;
   firq15_pkg::sample_type delay_ff [firq15_pkg::HIST_LEN];
   logic rsp_valid_ff, rsp_valid_in;
   firq15_pkg::sample_type rsp_sample_ff, rsp_sample_in;
   logic shift_in;

   firq15_pkg::mac_ctrl_type mac_ctrl;
   firq15_pkg::coef_type     coef;
   firq15_pkg::sample_type   operand;
   firq15_pkg::acc_type      acc;
   logic                     accept;
   logic                     out_free;

   assign accept   = req_valid && (state_ff == IDLE);
   assign out_free = !rsp_valid_ff || !rsp_stall;

   assign coef    = firq15_pkg::coef_at(idx_ff);
   assign operand = (idx_ff < firq15_pkg::IDX_W'(firq15_pkg::HIST_LEN)) ?
                    delay_ff[idx_ff[firq15_pkg::HIST_W-1:0]] : x_ff;

   always_comb begin
      mac_ctrl.clear  = accept;
      mac_ctrl.mul_en = (state_ff == RUN);
      mac_ctrl.acc_en = ((state_ff == RUN) && (idx_ff != '0)) || (state_ff == DRAIN);
   end

   firq15_mac u_mac (
      .clock (clock),
      .ctrl  (mac_ctrl),
      .coef  (coef),
      .data  (operand),
      .acc   (acc)
   );

   always_comb begin
      state_in      = state_ff;
      idx_in        = idx_ff;
      x_in          = x_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_sample_in = rsp_sample_ff;
      shift_in      = 1'b0;
      case (state_ff)
         IDLE: begin
            if (req_valid) begin
               x_in     = req_sample;
               idx_in   = '0;
               state_in = RUN;
            end
         end
         RUN: begin
            idx_in = idx_ff + 1'b1;
            if (idx_ff == firq15_pkg::IDX_W'(firq15_pkg::TAPS - 1)) begin
               state_in = DRAIN;
            end
         end
         DRAIN: begin
            state_in = DONE;
         end
         DONE: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_sample_in = acc[firq15_pkg::ACC_W-1 -: firq15_pkg::SAMPLE_W];
               shift_in      = 1'b1;
               state_in      = IDLE;
            end
         end
         default: begin
            state_in = IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= IDLE;
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         for (int j = 0; j < firq15_pkg::HIST_LEN; j++) begin
            delay_ff[j] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
         if (shift_in) begin
            for (int j = 0; j + 1 < firq15_pkg::HIST_LEN; j++) begin
               delay_ff[j] <= delay_ff[j+1];
            end
            delay_ff[firq15_pkg::HIST_LEN-1] <= x_ff;
         end
      end
      x_ff          <= x_in;
      rsp_sample_ff <= rsp_sample_in;
   end

   assign req_stall           = (state_ff != IDLE);
   assign rsp_valid           = rsp_valid_ff;
   assign rsp_filtered_sample = rsp_sample_ff;

endmodule

// ===== tb/sv/fir_filter_q15_saturating_tb.sv =====
// ----------------------------------------------------------------------------
// fir_filter_q15_saturating_tb
// Self-checking bench for the 31-tap Q15 saturating FIR filter.
// A queue-fed driver offers sample words with random gaps. A monitor predicts
// each filtered word from its own delay line and tap table when a sample is
// taken, and checks results in order as they leave. The receiver stalls at
// random and, twice, holds off long enough to back the block up. The run
// covers directed extremes, worst-case sign-matched bursts and random audio.
// ----------------------------------------------------------------------------
module fir_filter_q15_saturating_tb;

   localparam int NUM_WORDS   = 1450;
   localparam int IDLE_PCT    = 23;
   localparam int HOLD_CYCLES = 300;
   localparam int DRAIN_WAIT  = 40;

   localparam int FIR_COEF [31] = '{
      6, 52, -41, 62, 56, -231, 169, -377, -727, 86, -1904, -1084, -290,
      -5298, 3127, 24765, 3127, -5298, -290, -1084, -1904, 86, -727, -377,
      169, -231, 56, 62, -41, 52, 6
   };

   logic                   clock;
   logic                   reset;
   logic                   req_valid;
   logic                   req_stall;
   firq15_pkg::sample_type req_sample;
   logic                   rsp_valid;
   logic                   rsp_stall;
   firq15_pkg::sample_type rsp_filtered_sample;

   firq15_pkg::sample_type pending_words[$];
   firq15_pkg::sample_type expected_outputs[$];
   firq15_pkg::sample_type fir_history[30];
   logic                   req_taken;
   int                     words_in;
   int                     error_count;
   int                     hold_left;
   int                     holds_done;

   fir_filter_q15_saturating i_dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_sample          (req_sample),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_filtered_sample (rsp_filtered_sample)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // shifts the sample into the delay line, returns the filtered word
   function automatic firq15_pkg::sample_type filter_step(input firq15_pkg::sample_type x);
      longint acc;
      longint y;
      acc = 0;
      for (int j = 0; j < 30; j++) begin
         acc += longint'(FIR_COEF[j]) * longint'(fir_history[j]);
      end
      acc += longint'(FIR_COEF[30]) * longint'(x);
      y = acc >>> 16;
      if (y > 32767) begin
         y = 32767;
      end else if (y < -32768) begin
         y = -32768;
      end
      for (int j = 0; j < 29; j++) begin
         fir_history[j] = fir_history[j + 1];
      end
      fir_history[29] = x;
      return firq15_pkg::sample_type'(y[15:0]);
   endfunction

   function automatic logic calm_stretch();
      return words_in >= 700 && words_in < 950;
   endfunction

   // driver
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (req_taken || !req_valid) begin
         if (pending_words.size() != 0 &&
             (calm_stretch() || $urandom_range(99) >= IDLE_PCT)) begin
            req_valid  <= 1'b1;
            req_sample <= pending_words.pop_front();
         end else begin
            req_valid  <= 1'b0;
            req_sample <= firq15_pkg::sample_type'($urandom_range(65535));
         end
      end
      req_taken = 1'b0;
   end

   // receiver
   always @(negedge clock) begin
      if (hold_left > 0) begin
         rsp_stall <= 1'b1;
         hold_left = hold_left - 1;
      end else if ((holds_done == 0 && words_in >= 400) ||
                   (holds_done == 1 && words_in >= 1200)) begin
         rsp_stall <= 1'b1;
         hold_left = HOLD_CYCLES;
         holds_done = holds_done + 1;
      end else begin
         rsp_stall <= !calm_stretch() && $urandom_range(99) < IDLE_PCT;
      end
   end

   // monitor
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall) begin
            expected_outputs.push_back(filter_step(req_sample));
            words_in = words_in + 1;
            req_taken = 1'b1;
         end
         if (rsp_valid && !rsp_stall) begin
            if (expected_outputs.size() == 0) begin
               $display("%0t: unexpected word, expected none, actual %0d",
                        $time, rsp_filtered_sample);
               error_count = error_count + 1;
            end else if (rsp_filtered_sample !== expected_outputs[0]) begin
               $display("%0t: filtered_sample mismatch, expected %0d, actual %0d",
                        $time, expected_outputs[0], rsp_filtered_sample);
               error_count = error_count + 1;
               void'(expected_outputs.pop_front());
            end else begin
               void'(expected_outputs.pop_front());
            end
         end
      end
   end

   initial begin
      #5_000_000;
      $display("TB_ERROR");
      $finish;
   end

   initial begin
      int mode;
      logic polarity;
      reset       = 1'b1;
      req_valid   = 1'b0;
      req_sample  = '0;
      rsp_stall   = 1'b0;
      req_taken   = 1'b0;
      words_in    = 0;
      error_count = 0;
      hold_left   = 0;
      holds_done  = 0;
      foreach (fir_history[j]) fir_history[j] = '0;

      // directed: extremes, bit patterns, then the tail of a sign-matched run
      pending_words.push_back(16'sd0);
      pending_words.push_back(16'sd32767);
      pending_words.push_back(16'sd32767);
      pending_words.push_back(-16'sd32768);
      pending_words.push_back(-16'sd32768);
      pending_words.push_back(-16'sd1);
      pending_words.push_back(16'sd1);
      pending_words.push_back(firq15_pkg::sample_type'(16'h5555));
      pending_words.push_back(firq15_pkg::sample_type'(16'hAAAA));
      for (int j = 19; j < 31; j++) begin
         pending_words.push_back(FIR_COEF[j] >= 0 ? 16'sd32767 : -16'sd32768);
      end

      while (pending_words.size() < NUM_WORDS) begin
         mode = $urandom_range(99);
         if (mode < 4 && pending_words.size() + 31 <= NUM_WORDS) begin
            // full sign-matched burst drives the sum to its largest magnitude
            polarity = $urandom_range(1);
            for (int j = 0; j < 31; j++) begin
               pending_words.push_back(((FIR_COEF[j] >= 0) ^ polarity) ?
                                       16'sd32767 : -16'sd32768);
            end
         end else if (mode < 60) begin
            pending_words.push_back(firq15_pkg::sample_type'($urandom_range(65535)));
         end else if (mode < 80) begin
            pending_words.push_back(firq15_pkg::sample_type'($urandom_range(600) - 300));
         end else if (mode < 92) begin
            case ($urandom_range(3))
               0: pending_words.push_back(16'sd32767);
               1: pending_words.push_back(-16'sd32768);
               2: pending_words.push_back(-16'sd1);
               default: pending_words.push_back(16'sd0);
            endcase
         end else begin
            pending_words.push_back(firq15_pkg::sample_type'(
               $urandom_range(65535) >> $urandom_range(15)));
         end
      end

      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      while (!(pending_words.size() == 0 && !req_valid && expected_outputs.size() == 0))
         @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);

      if (error_count == 0 && expected_outputs.size() == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
